FILE: rtl/yaw_pitch_camera_update_macros.svh
// ----------------------------------------------------------------------------
// yaw_pitch_camera_update_macros
// assertion shorthands, clocked on aclk and disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef YAW_PITCH_CAMERA_UPDATE_MACROS_SVH
`define YAW_PITCH_CAMERA_UPDATE_MACROS_SVH

// same-cycle implication
`define YPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define YPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ypc_pkg.sv
// ----------------------------------------------------------------------------
// ypc_pkg
// shared types, opcodes and helper functions of the camera update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ypc_pkg;

    localparam logic [2:0] OP_STRAFE_L = 3'd0;
    localparam logic [2:0] OP_STRAFE_R = 3'd1;
    localparam logic [2:0] OP_FORWARD  = 3'd2;
    localparam logic [2:0] OP_BACKWARD = 3'd3;
    localparam logic [2:0] OP_LOOK     = 3'd4;

    localparam int YAW_FULL    = 3600;
    localparam int YAW_QUARTER = 900;
    localparam int PITCH_LIMIT = 890;

    localparam logic [31:0] RAD_PER_TENTH = 32'd1874033;

    // taylor divisors and their truncated 2^32 reciprocals
    localparam logic [31:0] SIN_DIVS [5] = '{32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
    localparam logic [31:0] SIN_RECIP [5] = '{
        32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)
    };

    typedef struct packed {
        logic       neg;
        logic [9:0] r;
    } sine_arg_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } sd_cmd_t;

    // input is offset so it is never negative, below 32 * 3600
    function automatic logic [11:0] yaw_wrap(input logic [16:0] v);
        logic [16:0] t;
        t = v;
        for (int i = 4; i >= 0; i--) begin
            if (t >= (17'(YAW_FULL) << i)) begin
                t = t - (17'(YAW_FULL) << i);
            end
        end
        return t[11:0];
    endfunction

    // fold an angle below 7200 tenths onto the first quadrant
    function automatic sine_arg_t sine_arg(input logic [12:0] a);
        logic [12:0] m;
        logic [12:0] r;
        logic [1:0]  q;
        sine_arg_t   res;
        m = (a >= 13'(YAW_FULL)) ? a - 13'(YAW_FULL) : a;
        if (m < 13'd900) begin
            q = 2'd0;
            r = m;
        end else if (m < 13'd1800) begin
            q = 2'd1;
            r = m - 13'd900;
        end else if (m < 13'd2700) begin
            q = 2'd2;
            r = m - 13'd1800;
        end else begin
            q = 2'd3;
            r = m - 13'd2700;
        end
        res.neg = q[1];
        res.r   = q[0] ? 10'(13'(YAW_QUARTER) - r) : r[9:0];
        return res;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [33:0] d);
        logic signed [34:0] s;
        s = 35'(a) + 35'(d);
        if (s > 35'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -35'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(s);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ypc_mul.sv
// ----------------------------------------------------------------------------
// ypc_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ypc_mul #(
    parameter int W = 33
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: rtl/ypc_sqdiv.sv
// ----------------------------------------------------------------------------
// ypc_sqdiv
// bit-serial unit: integer square root or restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ypc_sqdiv #(
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ypc_pkg::sd_cmd_t             cmd,
    input  logic [2*DIR_FRAC_BITS+1:0]   opa,
    input  logic [DIR_FRAC_BITS:0]       den,
    output logic                         done,
    output logic [2*DIR_FRAC_BITS+1:0]   result
);

    localparam int F  = DIR_FRAC_BITS;
    localparam int SW = 2 * F + 2;
    localparam int CW = $clog2(SW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic          sqrt_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] v_reg;
    logic [SW-1:0] res_reg;
    logic [SW-1:0] bit_reg;
    logic [F+1:0]  rem_reg;
    logic [SW-1:0] quo_reg;
    logic [F:0]    den_reg;

    logic [SW-1:0] sq_sum;
    logic [F+1:0]  trial;

    assign sq_sum = res_reg + bit_reg;
    assign trial  = {rem_reg[F:0], quo_reg[SW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            sqrt_reg <= cmd.sqrt_mode;
            cnt_reg  <= cmd.sqrt_mode ? CW'(F + 1) : CW'(SW);
            v_reg    <= opa;
            res_reg  <= '0;
            bit_reg  <= SW'(1) << (SW - 2);
            rem_reg  <= '0;
            quo_reg  <= opa;
            den_reg  <= den;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (sqrt_reg) begin
                if (v_reg >= sq_sum) begin
                    v_reg   <= v_reg - sq_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end else begin
                if (trial >= (F + 2)'(den_reg)) begin
                    rem_reg <= trial - (F + 2)'(den_reg);
                    quo_reg <= {quo_reg[SW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[SW-2:0], 1'b0};
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = sqrt_reg ? res_reg : quo_reg;

endmodule

`default_nettype wire

FILE: rtl/yaw_pitch_camera_update.sv
// look: four sines on the shared multiplier, with three multiply steps per
//   taylor division, then the view direction products
// move forward/back: multiply and saturating add per axis; strafe: bit-serial
//   square root and two divides; unused opcodes go straight to the result
// one event at a time; s_ready is high only while the sequencer is idle
// synchronous active-low reset restores position, direction, angles and speed
// ----------------------------------------------------------------------------
// yaw_pitch_camera_update
// first-person camera: look, move and strafe events on a shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module yaw_pitch_camera_update #(
    parameter int POS_FRAC_BITS = 16,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [22:0]                   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_operation,
    input  logic signed [15:0]            s_delta_x,
    input  logic signed [15:0]            s_delta_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_eye_x,
    output logic signed [31:0]            m_eye_y,
    output logic signed [31:0]            m_eye_z,
    output logic signed [DIR_FRAC_BITS+1:0] m_dir_x,
    output logic signed [DIR_FRAC_BITS+1:0] m_dir_y,
    output logic signed [DIR_FRAC_BITS+1:0] m_dir_z,
    output logic [11:0]                   m_yaw_now,
    output logic signed [10:0]            m_pitch_now
);

    import ypc_pkg::*;

    localparam int F  = DIR_FRAC_BITS;
    localparam int DW = F + 2;
    localparam int HW = DW + 1;
    localparam int SW = 2 * F + 2;
    localparam int MW = 33;
    localparam int PW = 2 * MW;
    localparam int SH = 30 - F;

    localparam logic signed [31:0] POS_Z_RST  = 32'(64'd5 << POS_FRAC_BITS);
    localparam logic [DW-1:0]      ONE_F      = DW'(1) << F;
    localparam logic signed [DW-1:0] VIEW_Z_RST = -(DW'(1) << F);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_LK_ANG  = 5'd1;
    localparam logic [4:0] ST_SN_X    = 5'd2;
    localparam logic [4:0] ST_SN_X2   = 5'd3;
    localparam logic [4:0] ST_SN_DIV  = 5'd4;
    localparam logic [4:0] ST_SN_DQ   = 5'd5;
    localparam logic [4:0] ST_SN_DR   = 5'd6;
    localparam logic [4:0] ST_SN_S    = 5'd7;
    localparam logic [4:0] ST_LK_M1   = 5'd8;
    localparam logic [4:0] ST_LK_M2   = 5'd9;
    localparam logic [4:0] ST_LK_M3   = 5'd10;
    localparam logic [4:0] ST_MV_MUL  = 5'd11;
    localparam logic [4:0] ST_MV_ADD  = 5'd12;
    localparam logic [4:0] ST_STR_SQ1 = 5'd13;
    localparam logic [4:0] ST_STR_SQ2 = 5'd14;
    localparam logic [4:0] ST_STR_SQ3 = 5'd15;
    localparam logic [4:0] ST_STR_SQW = 5'd16;
    localparam logic [4:0] ST_STR_DVW = 5'd17;
    localparam logic [4:0] ST_STR_ADD = 5'd18;
    localparam logic [4:0] ST_DONE    = 5'd19;

    // ties round away from zero
    function automatic logic signed [PW-1:0] rnd_dir(input logic signed [PW-1:0] v);
        logic          neg;
        logic [PW-1:0] mag;
        neg = v[PW-1];
        mag = neg ? PW'(-v) : PW'(v);
        mag = (mag + (PW'(1) << (F - 1))) >> F;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    logic [4:0]              state_reg, state_next;
    logic                    m_valid_reg;
    logic [22:0]             speed_reg;
    logic signed [31:0]      pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [DW-1:0]    view_x_reg, view_y_reg, view_z_reg;
    logic [11:0]             yaw_reg;
    logic signed [10:0]      pitch_reg;

    logic [2:0]              op_reg;
    logic signed [15:0]      dx_reg, dy_reg;
    logic [2:0]              k_reg;
    logic [1:0]              j_reg;
    logic [31:0]             xs_reg, x2_reg, yv_reg, qv_reg;
    logic signed [DW-1:0]    sin_reg [4];
    logic [SW-1:0]           hsq_reg;
    logic [F:0]              len_reg;

    logic signed [31:0]      out_ex_reg, out_ey_reg, out_ez_reg;
    logic signed [DW-1:0]    out_dx_reg, out_dy_reg, out_dz_reg;
    logic [11:0]             out_yaw_reg;
    logic signed [10:0]      out_pitch_reg;

    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]    prod;

    ypc_pkg::sd_cmd_t        sd_cmd;
    logic [SW-1:0]           sd_opa;
    logic [F:0]              sd_den;
    logic                    sd_done;
    logic [SW-1:0]           sd_result;

    logic                    out_free;
    logic                    accept;

    // angle update
    logic signed [18:0]      ysum;
    logic signed [17:0]      psum;
    logic [11:0]             yaw_new;
    logic signed [10:0]      pitch_new;

    // sine step
    logic [12:0]             pa;
    logic [12:0]             ang;
    sine_arg_t               sa;
    logic [31:0]             rem_c, qf;
    logic [30:0]             t_new;
    logic [32:0]             sv_u;
    logic signed [DW-1:0]    sval;

    // move and strafe
    logic signed [DW-1:0]    view_k;
    logic signed [31:0]      pos_k;
    logic signed [33:0]      rd, step_d;
    logic signed [HW-1:0]    hx, hz, hdiv, hcomp;
    logic [HW-1:0]           hdiv_mag;
    logic [F:0]              len_cur;
    logic [DW-1:0]           qc;
    logic signed [DW-1:0]    comp;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && (state_reg == ST_IDLE);

    assign ysum      = $signed({7'b0, yaw_reg}) + 19'(dx_reg) + 19'sd36000;
    assign yaw_new   = yaw_wrap(ysum[16:0]);
    assign psum      = 18'(pitch_reg) + 18'(dy_reg);
    assign pitch_new = (psum > 18'sd890) ? 11'sd890 :
                       (psum < -18'sd890) ? -11'sd890 : 11'(psum);

    assign pa = 13'(14'(pitch_reg) + 14'sd3600);
    always_comb begin
        case (j_reg)
            2'd0:    ang = 13'(yaw_reg) + 13'(YAW_QUARTER);
            2'd1:    ang = 13'(yaw_reg);
            2'd2:    ang = pa + 13'(YAW_QUARTER);
            default: ang = pa;
        endcase
    end
    assign sa = sine_arg(ang);

    assign rem_c = yv_reg - prod[31:0];
    assign qf    = qv_reg + 32'(rem_c >= SIN_DIVS[k_reg]);
    assign t_new = 31'((32'd1 << 30) - qf);
    assign sv_u  = (33'(prod[61:30]) + (33'd1 << (SH - 1))) >> SH;
    assign sval  = DW'(sv_u);

    always_comb begin
        case (k_reg)
            3'd0:    begin view_k = view_x_reg; pos_k = pos_x_reg; end
            3'd1:    begin view_k = view_y_reg; pos_k = pos_y_reg; end
            default: begin view_k = view_z_reg; pos_k = pos_z_reg; end
        endcase
    end

    assign rd     = 34'(rnd_dir(prod));
    assign step_d = (op_reg == OP_BACKWARD) ? -rd : rd;

    // horizontal vector across the view, flipped for strafe right
    assign hx = (op_reg == OP_STRAFE_R) ? -HW'(view_z_reg) : HW'(view_z_reg);
    assign hz = (op_reg == OP_STRAFE_R) ? HW'(view_x_reg) : -HW'(view_x_reg);

    assign hdiv     = (state_reg == ST_STR_ADD) ? hz : hx;
    assign hdiv_mag = hdiv[HW-1] ? HW'(-hdiv) : HW'(hdiv);
    assign len_cur  = (state_reg == ST_STR_SQW) ? sd_result[F:0] : len_reg;

    assign hcomp = k_reg[0] ? hz : hx;
    assign qc    = (sd_result > SW'(ONE_F)) ? ONE_F : sd_result[DW-1:0];
    assign comp  = hcomp[HW-1] ? -$signed(qc) : $signed(qc);

    always_comb begin
        sd_cmd.sqrt_mode = (state_reg == ST_STR_SQ3);
        sd_cmd.start     = (state_reg == ST_STR_SQ3) ||
                           (state_reg == ST_STR_SQW && sd_done && sd_result != '0) ||
                           (state_reg == ST_STR_ADD && !k_reg[0]);
        sd_opa = (state_reg == ST_STR_SQ3) ? SW'(hsq_reg + prod[SW-1:0])
                                           : SW'((SW'(hdiv_mag) << F) + SW'(len_cur >> 1));
        sd_den = len_cur;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SN_X: begin
                mul_a = MW'(sa.r);
                mul_b = {1'b0, RAD_PER_TENTH};
            end
            ST_SN_X2: begin
                mul_a = {1'b0, prod[31:0]};
                mul_b = {1'b0, prod[31:0]};
            end
            ST_SN_DIV: begin
                mul_a = {1'b0, prod[61:30]};
                mul_b = {1'b0, SIN_RECIP[k_reg]};
            end
            ST_SN_DQ: begin
                mul_a = {1'b0, prod[63:32]};
                mul_b = {1'b0, SIN_DIVS[k_reg]};
            end
            ST_SN_DR: begin
                mul_a = (k_reg == 3'd4) ? {1'b0, xs_reg} : {1'b0, x2_reg};
                mul_b = {2'b0, t_new};
            end
            ST_LK_M1: begin
                mul_a = MW'(sin_reg[0]);
                mul_b = MW'(sin_reg[2]);
            end
            ST_LK_M2: begin
                mul_a = MW'(sin_reg[1]);
                mul_b = MW'(sin_reg[2]);
            end
            ST_MV_MUL: begin
                mul_a = {10'b0, speed_reg};
                mul_b = MW'(view_k);
            end
            ST_STR_SQ1: begin
                mul_a = MW'(hx);
                mul_b = MW'(hx);
            end
            ST_STR_SQ2: begin
                mul_a = MW'(hz);
                mul_b = MW'(hz);
            end
            ST_STR_DVW: begin
                mul_a = {10'b0, speed_reg};
                mul_b = MW'(comp);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ypc_mul #(.W(MW)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    ypc_sqdiv #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_sqdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sd_cmd),
        .opa     (sd_opa),
        .den     (sd_den),
        .done    (sd_done),
        .result  (sd_result)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_operation) inside
                        OP_LOOK:                  state_next = ST_LK_ANG;
                        OP_FORWARD, OP_BACKWARD:  state_next = ST_MV_MUL;
                        OP_STRAFE_L, OP_STRAFE_R: state_next = ST_STR_SQ1;
                        default:                  state_next = ST_DONE;
                    endcase
                end
            end
            ST_LK_ANG:  state_next = ST_SN_X;
            ST_SN_X:    state_next = ST_SN_X2;
            ST_SN_X2:   state_next = ST_SN_DIV;
            ST_SN_DIV:  state_next = ST_SN_DQ;
            ST_SN_DQ:   state_next = ST_SN_DR;
            ST_SN_DR:   state_next = (k_reg == 3'd4) ? ST_SN_S : ST_SN_DIV;
            ST_SN_S:    state_next = (j_reg == 2'd3) ? ST_LK_M1 : ST_SN_X;
            ST_LK_M1:   state_next = ST_LK_M2;
            ST_LK_M2:   state_next = ST_LK_M3;
            ST_LK_M3:   state_next = ST_DONE;
            ST_MV_MUL:  state_next = ST_MV_ADD;
            ST_MV_ADD:  state_next = (k_reg == 3'd2) ? ST_DONE : ST_MV_MUL;
            ST_STR_SQ1: state_next = ST_STR_SQ2;
            ST_STR_SQ2: state_next = ST_STR_SQ3;
            ST_STR_SQ3: state_next = ST_STR_SQW;
            ST_STR_SQW: begin
                // a zero-length horizontal vector leaves the eye in place
                if (sd_done) begin
                    state_next = (sd_result == '0) ? ST_DONE : ST_STR_DVW;
                end
            end
            ST_STR_DVW: begin
                if (sd_done) begin
                    state_next = ST_STR_ADD;
                end
            end
            ST_STR_ADD: state_next = k_reg[0] ? ST_DONE : ST_STR_DVW;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            speed_reg   <= 23'd6554;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= POS_Z_RST;
            view_x_reg  <= '0;
            view_y_reg  <= '0;
            view_z_reg  <= VIEW_Z_RST;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                speed_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_LK_ANG) begin
                yaw_reg   <= yaw_new;
                pitch_reg <= pitch_new;
            end
            if (state_reg == ST_LK_M2) begin
                view_x_reg <= DW'(rnd_dir(prod));
            end
            if (state_reg == ST_LK_M3) begin
                view_z_reg <= DW'(rnd_dir(prod));
                view_y_reg <= sin_reg[3];
            end
            if (state_reg == ST_MV_ADD) begin
                case (k_reg)
                    3'd0:    pos_x_reg <= sat_add(pos_k, step_d);
                    3'd1:    pos_y_reg <= sat_add(pos_k, step_d);
                    default: pos_z_reg <= sat_add(pos_k, step_d);
                endcase
            end
            if (state_reg == ST_STR_ADD) begin
                if (k_reg[0]) begin
                    pos_z_reg <= sat_add(pos_z_reg, rd);
                end else begin
                    pos_x_reg <= sat_add(pos_x_reg, rd);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_operation;
            dx_reg <= s_delta_x;
            dy_reg <= s_delta_y;
            k_reg  <= '0;
            j_reg  <= '0;
        end
        unique case (state_reg)
            ST_SN_X:  k_reg <= '0;
            ST_SN_X2: xs_reg <= prod[31:0];
            ST_SN_DIV: begin
                yv_reg <= prod[61:30];
                if (k_reg == 3'd0) begin
                    x2_reg <= prod[61:30];
                end
            end
            ST_SN_DQ: qv_reg <= prod[63:32];
            ST_SN_DR: begin
                if (k_reg != 3'd4) begin
                    k_reg <= k_reg + 3'd1;
                end
            end
            ST_SN_S: begin
                sin_reg[j_reg] <= sa.neg ? -sval : sval;
                j_reg          <= j_reg + 2'd1;
            end
            ST_MV_ADD:  k_reg <= k_reg + 3'd1;
            ST_STR_SQ2: hsq_reg <= prod[SW-1:0];
            ST_STR_SQW: begin
                if (sd_done) begin
                    len_reg <= sd_result[F:0];
                    k_reg   <= '0;
                end
            end
            ST_STR_ADD: k_reg <= 3'd1;
            default: begin
            end
        endcase
        if (state_reg == ST_DONE && out_free) begin
            out_ex_reg    <= pos_x_reg;
            out_ey_reg    <= pos_y_reg;
            out_ez_reg    <= pos_z_reg;
            out_dx_reg    <= view_x_reg;
            out_dy_reg    <= view_y_reg;
            out_dz_reg    <= view_z_reg;
            out_yaw_reg   <= yaw_reg;
            out_pitch_reg <= pitch_reg;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_eye_x     = out_ex_reg;
    assign m_eye_y     = out_ey_reg;
    assign m_eye_z     = out_ez_reg;
    assign m_dir_x     = out_dx_reg;
    assign m_dir_y     = out_dy_reg;
    assign m_dir_z     = out_dz_reg;
    assign m_yaw_now   = out_yaw_reg;
    assign m_pitch_now = out_pitch_reg;

endmodule

`default_nettype wire

FILE: rtl/ypc_checker.sv
// ----------------------------------------------------------------------------
// ypc_checker
// port-level checks of the camera update block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "yaw_pitch_camera_update_macros.svh"

module ypc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [11:0]        m_yaw_now,
    input logic signed [10:0] m_pitch_now
);

    // a stalled result stays up
    `YPC_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // one event at a time: busy right after an input transfer
    `YPC_ASSERT_NEXT(a_busy, s_valid && s_ready, !s_ready, "ready right after transfer")

    `YPC_ASSERT_NOW(a_yaw_rng, m_valid, m_yaw_now < 12'd3600, "yaw out of range")

    `YPC_ASSERT_NOW(a_pitch_rng, m_valid,
        m_pitch_now <= 11'sd890 && m_pitch_now >= -11'sd890, "pitch out of range")

endmodule

bind yaw_pitch_camera_update ypc_checker u_ypc_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the camera update block against a cycle-free model of its math:
// directed and random look, move, strafe and unused-opcode events under several speeds,
// with bursty input traffic and a stalling result receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import ypc_pkg::*;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } cam_event_t;

    typedef struct {
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [11:0]        yaw;
        logic signed [10:0] pitch;
    } cam_view_t;

    localparam int DIRF = 14;
    localparam int SPEED_MAX = 4194304;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [22:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_operation = '0;
    logic signed [15:0] s_delta_x = '0;
    logic signed [15:0] s_delta_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_eye_x, m_eye_y, m_eye_z;
    logic signed [15:0] m_dir_x, m_dir_y, m_dir_z;
    logic [11:0] m_yaw_now;
    logic signed [10:0] m_pitch_now;

    yaw_pitch_camera_update dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_delta_x(s_delta_x), .s_delta_y(s_delta_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_eye_x(m_eye_x), .m_eye_y(m_eye_y), .m_eye_z(m_eye_z),
        .m_dir_x(m_dir_x), .m_dir_y(m_dir_y), .m_dir_z(m_dir_z),
        .m_yaw_now(m_yaw_now), .m_pitch_now(m_pitch_now)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cam_event_t event_q[$];
    cam_view_t  view_q[$];
    int mismatches = 0;

    // camera state as the block should hold it
    int cam_px, cam_py, cam_pz, cam_vx, cam_vy, cam_vz, cam_yaw, cam_pitch;
    longint unsigned cam_speed;

    function automatic longint round_away(longint v, int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic int clamp_add(int a, longint d);
        longint s;
        s = longint'(a) + d;
        if (s > 64'sd2147483647) return 32'h7FFFFFFF;
        if (s < -64'sd2147483648) return 32'h80000000;
        return int'(s);
    endfunction

    function automatic int quarter_sin(int unsigned r);
        longint unsigned one, x, x2, t, s;
        one = 64'd1 << 30;
        x = longint'(r) * 64'd1874033;
        x2 = (x * x) >> 30;
        t = one - x2 / 110;
        t = one - ((x2 * t) >> 30) / 72;
        t = one - ((x2 * t) >> 30) / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        return int'((s + (64'd1 << (29 - DIRF))) >> (30 - DIRF));
    endfunction

    function automatic int sin_tenths(int unsigned a);
        int unsigned q, r;
        int v;
        a = a % YAW_FULL;
        q = a / YAW_QUARTER;
        r = a % YAW_QUARTER;
        v = q[0] ? quarter_sin(YAW_QUARTER - r) : quarter_sin(r);
        return (q >= 2) ? -v : v;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic int unit_part(int h, longint unsigned len);
        longint unsigned m, q;
        m = (h < 0) ? longint'(-h) : longint'(h);
        q = ((m << DIRF) + len / 2) / len;
        if (q > (64'd1 << DIRF)) q = 64'd1 << DIRF;
        return (h < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic longint speed_mul(int c);
        return round_away(longint'(cam_speed) * c, DIRF);
    endfunction

    function automatic cam_view_t camera_next(cam_event_t e);
        int y, p, cy, sy, cp, sp, hx, hz;
        longint dx, dy, dz;
        longint unsigned len;
        cam_view_t r;
        if (e.op == OP_LOOK) begin
            y = (cam_yaw + int'(e.dx)) % YAW_FULL;
            if (y < 0) y += YAW_FULL;
            p = cam_pitch + int'(e.dy);
            if (p > PITCH_LIMIT) p = PITCH_LIMIT;
            if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
            cam_yaw = y;
            cam_pitch = p;
            cy = sin_tenths(y + YAW_QUARTER);
            sy = sin_tenths(y);
            cp = sin_tenths(p + YAW_FULL + YAW_QUARTER);
            sp = sin_tenths(p + YAW_FULL);
            cam_vx = int'(round_away(longint'(cy) * cp, DIRF));
            cam_vy = sp;
            cam_vz = int'(round_away(longint'(sy) * cp, DIRF));
        end else if (e.op == OP_FORWARD || e.op == OP_BACKWARD) begin
            dx = speed_mul(cam_vx);
            dy = speed_mul(cam_vy);
            dz = speed_mul(cam_vz);
            if (e.op == OP_BACKWARD) begin
                dx = -dx; dy = -dy; dz = -dz;
            end
            cam_px = clamp_add(cam_px, dx);
            cam_py = clamp_add(cam_py, dy);
            cam_pz = clamp_add(cam_pz, dz);
        end else if (e.op == OP_STRAFE_L || e.op == OP_STRAFE_R) begin
            hx = cam_vz;
            hz = -cam_vx;
            if (e.op == OP_STRAFE_R) begin
                hx = -hx; hz = -hz;
            end
            len = isqrt(longint'(hx) * hx + longint'(hz) * hz);
            // zero-length horizontal vector leaves the eye where it is
            if (len != 0) begin
                cam_px = clamp_add(cam_px, speed_mul(unit_part(hx, len)));
                cam_pz = clamp_add(cam_pz, speed_mul(unit_part(hz, len)));
            end
        end
        r.ex = cam_px; r.ey = cam_py; r.ez = cam_pz;
        r.vx = cam_vx[15:0]; r.vy = cam_vy[15:0]; r.vz = cam_vz[15:0];
        r.yaw = cam_yaw[11:0]; r.pitch = cam_pitch[10:0];
        return r;
    endfunction

    // driver: bursts of transfers separated by random gaps
    int burst_left = 1;
    int gap_left = 0;
    always @(posedge aclk) begin
        cam_event_t e;
        logic took;
        if (aresetn) begin
            took = s_valid && s_ready;
            if (took) begin
                e.op = s_operation; e.dx = s_delta_x; e.dy = s_delta_y;
                view_q.insert(view_q.size(), camera_next(e));
            end
            if (gap_left > 0) gap_left--;
            if (!s_valid || took) begin
                if (gap_left == 0 && event_q.size() > 0) begin
                    e = event_q.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= e.op;
                    s_delta_x <= e.dx;
                    s_delta_y <= e.dy;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, refreshed after each pass through its 32 bits
    logic [31:0] stall_bits = '1;
    int stall_pos = 0;
    always @(posedge aclk) begin
        if (stall_pos == 31) begin
            case ($urandom_range(0, 3))
                0: stall_bits = '1;
                1: stall_bits = $urandom();
                2: stall_bits = $urandom() | $urandom();
                default: stall_bits = $urandom() & $urandom();
            endcase
        end
        stall_pos = (stall_pos + 1) % 32;
        m_ready <= stall_bits[stall_pos];
    end

    // monitor
    always @(posedge aclk) begin
        cam_view_t w;
        if (aresetn && m_valid && m_ready) begin
            if (view_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
                w = view_q.pop_front();
                if (w.ex !== m_eye_x || w.ey !== m_eye_y || w.ez !== m_eye_z ||
                    w.vx !== m_dir_x || w.vy !== m_dir_y || w.vz !== m_dir_z ||
                    w.yaw !== m_yaw_now || w.pitch !== m_pitch_now) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp eye %0d %0d %0d dir %0d %0d %0d yaw %0d pitch %0d",
                                 $realtime, w.ex, w.ey, w.ez, w.vx, w.vy, w.vz, w.yaw, w.pitch);
                        $display("             got eye %0d %0d %0d dir %0d %0d %0d yaw %0d pitch %0d",
                                 m_eye_x, m_eye_y, m_eye_z, m_dir_x, m_dir_y, m_dir_z,
                                 m_yaw_now, m_pitch_now);
                    end
                end
            end
        end
    end

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (event_q.size() != 0 || s_valid || view_q.size() != 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_speed(int unsigned v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[22:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cam_speed = v & 32'h7FFFFF;
    endtask

    task automatic push_event(logic [2:0] op, int dx, int dy);
        cam_event_t e;
        e.op = op; e.dx = dx[15:0]; e.dy = dy[15:0];
        event_q.insert(event_q.size(), e);
    endtask

    // mostly legal camera events; move_bias favors forward/backward
    task automatic push_random(int n, int move_bias);
        int k;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 3) op = 3'($urandom_range(5, 7));
            else if (k < 3 + move_bias) op = $urandom_range(0, 1) ? OP_FORWARD : OP_BACKWARD;
            else op = 3'($urandom_range(0, 4));
            if (op == OP_LOOK && $urandom_range(0, 9) < 7)
                push_event(op, $urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300);
            else
                push_event(op, $urandom(), $urandom());
        end
    endtask

    initial begin
        cam_px = 0; cam_py = 0; cam_pz = 5 << 16;
        cam_vx = 0; cam_vy = 0; cam_vz = -16384;
        cam_yaw = 0; cam_pitch = 0; cam_speed = 6554;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset direction used before any look, then every opcode and extreme
        push_event(OP_FORWARD, 0, 0);
        push_event(OP_STRAFE_L, 0, 0);
        push_event(OP_STRAFE_R, 0, 0);
        push_event(OP_BACKWARD, 0, 0);
        push_event(3'd5, 1, 1);
        push_event(3'd6, -1, -1);
        push_event(3'd7, 32767, -32768);
        push_event(OP_LOOK, 32767, 32767);
        push_event(OP_FORWARD, 0, 0);
        push_event(OP_LOOK, -32768, -32768);
        push_event(OP_STRAFE_L, 0, 0);
        push_event(OP_LOOK, 3599, 1780);
        push_event(OP_STRAFE_R, 0, 0);
        push_event(OP_LOOK, -3600, -1);
        push_event(OP_LOOK, 900, -1779);
        push_event(OP_BACKWARD, 0, 0);
        push_event(OP_LOOK, -1, 0);
        push_event(OP_LOOK, 1, 890);
        push_event(OP_FORWARD, -1, -1);
        wait_idle();

        set_speed(0);
        push_random(300, 20);
        wait_idle();

        // SPEED_MAX (2^22, half the speed range) pushes the eye into saturation
        set_speed(SPEED_MAX);
        push_random(700, 75);
        wait_idle();

        set_speed($urandom_range(0, SPEED_MAX));
        push_random(400, 20);
        wait_idle();

        set_speed($urandom_range(1, 100));
        push_random(200, 20);
        wait_idle();

        set_speed(6554);
        push_random(250, 20);
        wait_idle();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ypc_pkg.sv
rtl/ypc_mul.sv
rtl/ypc_sqdiv.sv
rtl/yaw_pitch_camera_update.sv
rtl/ypc_checker.sv
tb/tb_top.sv
